/* rtl/c3rb_pkg.sv */
// ----------------------------------------------------------------------------
// c3rb_pkg: shared types and constants
// Widths, register indexes and the per-channel filter arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
package c3rb_pkg;
   localparam int MAX_WIDTH      = 2048;
   localparam int COEF_FRAC_BITS = 12;
   localparam int COL_W          = $clog2(MAX_WIDTH);
   localparam int PIX_W          = 24;
   localparam int ACC_W          = 30;
   localparam int OUT_DEPTH      = 8;
   localparam int OUT_PTR_W      = 3;
   localparam int OUT_W          = PIX_W + 2;

   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_MIRROR = 3'd2;
   localparam logic [2:0] REG_KTOP   = 3'd3;
   localparam logic [2:0] REG_KMID   = 3'd4;
   localparam logic [2:0] REG_KBOT   = 3'd5;

   typedef logic [PIX_W-1:0] pix_type;

   // One result request: which window rows and columns the kernel reads.
   // The third kernel row and column always read window row and column two.
   typedef struct packed {
      logic       valid;
      logic [1:0] r0, r1, c0, c1;
      logic       last;
      logic       fend;
   } job_type;

   function automatic logic [7:0] clamp_sum(input logic signed [ACC_W-1:0] s);
      logic signed [ACC_W-1:0] q;
      q = s >>> COEF_FRAC_BITS;
      if (s < 0) return 8'd0;
      if (q > 255) return 8'd255;
      return q[7:0];
   endfunction
endpackage
`default_nettype wire

/* rtl/c3rb_ram.sv */
// ----------------------------------------------------------------------------
// c3rb_ram: generic single-port RAM
// One read a cycle with an optional write to the same address, read data
// registered and taken before the write.
// ----------------------------------------------------------------------------
`default_nettype none
module c3rb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (en) begin
         rdata <= mem_ff[addr];
         if (we) mem_ff[addr] <= wdata;
      end
   end
endmodule
`default_nettype wire

/* rtl/c3rb_cell.sv */
// ----------------------------------------------------------------------------
// c3rb_cell: one window column cell
// Holds one column of three pixels and hands it to its left neighbor.
// ----------------------------------------------------------------------------
`default_nettype none
module c3rb_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift,
   input  wire c3rb_pkg::pix_type col_in [3],
   output c3rb_pkg::pix_type      col_out [3]
);
   import c3rb_pkg::*;
   pix_type col_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) col_ff[i] <= '0;
      end else if (shift) begin
         for (int i = 0; i < 3; i++) col_ff[i] <= col_in[i];
      end
   end
   assign col_out = col_ff;
endmodule
`default_nettype wire

/* rtl/c3rb_mac.sv */
// ----------------------------------------------------------------------------
// c3rb_mac: kernel datapath
// Selects the mirrored window taps and registers the products; the sum and
// the clamp are combinational on the registered products.
// ----------------------------------------------------------------------------
`default_nettype none
module c3rb_mac (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire c3rb_pkg::pix_type win [9],
   input  wire c3rb_pkg::job_type job,
   input  wire logic [47:0]       krow [3],
   output c3rb_pkg::job_type      job_out,
   output logic [7:0]             ch_out [3]
);
   import c3rb_pkg::*;
   logic signed [24:0] prod_ff [3][9];
   job_type job_ff;
   logic [1:0] rsel [3], csel [3];
   logic [3:0] tap [3][3];

   always_comb begin
      rsel[0] = job.r0; rsel[1] = job.r1; rsel[2] = 2'd2;
      csel[0] = job.c0; csel[1] = job.c1; csel[2] = 2'd2;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            tap[i][j] = 4'(rsel[i]) * 4'd3 + 4'(csel[j]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            for (int ch = 0; ch < 3; ch++)
               prod_ff[ch][i*3+j] <= $signed({1'b0,
                  win[tap[i][j]][16-8*ch +: 8]}) *
                  $signed(krow[i][16*j +: 16]);
      if (reset) job_ff <= '0;
      else job_ff <= job;
   end

   always_comb begin
      logic signed [ACC_W-1:0] s;
      for (int ch = 0; ch < 3; ch++) begin
         s = '0;
         for (int k = 0; k < 9; k++) s = s + ACC_W'(prod_ff[ch][k]);
         ch_out[ch] = clamp_sum(s);
      end
   end
   assign job_out = job_ff;
endmodule
`default_nettype wire

/* rtl/convolution_3x3_reflect_border.sv */
// ----------------------------------------------------------------------------
// convolution_3x3_reflect_border: 3x3 RGB filter with mirrored borders
// Line stores, a row of window cells and a kernel datapath.
// ----------------------------------------------------------------------------
// A pixel is taken in each cycle that req_stall is low. With mirroring on, a
// pixel that yields results and ends a row or falls on the last row yields two,
// the last pixel of the frame four, and each holds stall high for each of its
// extra results. Results leave one a cycle while rsp_stall is low; the first
// result of a pixel passes the line store read, window shift, multiply stage and
// output buffer write. An eight-beat output buffer absorbs output stalls; input
// stalls once more than four results are outstanding.
`default_nettype none
module convolution_3x3_reflect_border (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic             rsp_last_of_run,
   output logic             rsp_frame_end,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [5:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);
   import c3rb_pkg::*;

   logic [11:0] width_ff, height_ff;
   logic        mirror_ff;
   logic [47:0] krow_ff [3];
   logic [11:0] row_ff, col_ff;
   logic        wr;
   logic [2:0]  ridx;

   assign pready = 1'b1;
   assign ridx   = paddr[5:3];
   assign wr     = psel && penable && pwrite;

   always_comb begin
      unique case (ridx)
         REG_WIDTH:  prdata = 64'(width_ff);
         REG_HEIGHT: prdata = 64'(height_ff);
         REG_MIRROR: prdata = 64'(mirror_ff);
         REG_KTOP:   prdata = 64'(krow_ff[0]);
         REG_KMID:   prdata = 64'(krow_ff[1]);
         REG_KBOT:   prdata = 64'(krow_ff[2]);
         default:    prdata = '0;
      endcase
   end

   logic [11:0] w_eff, h_eff, c_eff, r_eff;
   logic        row_end, last_row, ok;
   logic [1:0]  extra;
   logic [2:0]  nres;
   always_comb begin
      w_eff = (width_ff < 12'd3) ? 12'd3 :
              (width_ff > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : width_ff;
      h_eff = (height_ff < 12'd3) ? 12'd3 : height_ff;
      c_eff = (col_ff >= w_eff) ? w_eff - 12'd1 : col_ff;
      r_eff = (row_ff >= h_eff) ? h_eff - 12'd1 : row_ff;
      row_end  = (c_eff == w_eff - 12'd1);
      last_row = (r_eff == h_eff - 12'd1);
      ok = mirror_ff ? (r_eff >= 12'd1 && c_eff >= 12'd1) :
                       (r_eff >= 12'd2 && c_eff >= 12'd2);
      extra = !(ok && mirror_ff) ? 2'd0 :
              (last_row && row_end) ? 2'd3 :
              (last_row || row_end) ? 2'd1 : 2'd0;
      nres = ok ? 3'(extra) + 3'd1 : 3'd0;
   end

   logic [1:0] pend_ff;
   logic [3:0] cnt_ff;
   logic       acc, pop;
   assign req_stall = (pend_ff != 2'd0) || (cnt_ff > 4'(OUT_DEPTH - 4));
   assign acc = req_valid && !req_stall;
   assign pop = rsp_valid && !rsp_stall;

   // Row r is written to bank r[0], so that bank returns row r-2 and the
   // other bank returns row r-1 at the same column.
   pix_type pix, pix_ff, rd0, rd1, up, lo;
   logic    bank_ff;
   assign pix = {req_red_in, req_green_in, req_blue_in};

   c3rb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank0 (
      .clock(clock), .en(acc), .we(!r_eff[0]), .addr(c_eff[COL_W-1:0]),
      .wdata(pix), .rdata(rd0));
   c3rb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank1 (
      .clock(clock), .en(acc), .we(r_eff[0]), .addr(c_eff[COL_W-1:0]),
      .wdata(pix), .rdata(rd1));

   assign up = bank_ff ? rd1 : rd0;
   assign lo = bank_ff ? rd0 : rd1;

   logic s1_ff, m1_ff, ok1_ff, r11_ff, c11_ff, re1_ff, lr1_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_ff <= 1'b0;
      else s1_ff <= acc;
      if (acc) begin
         pix_ff  <= pix;
         bank_ff <= r_eff[0];
         m1_ff   <= mirror_ff;
         ok1_ff  <= ok;
         r11_ff  <= (r_eff == 12'd1);
         c11_ff  <= (c_eff == 12'd1);
         re1_ff  <= row_end;
         lr1_ff  <= last_row;
      end
   end

   pix_type ci [3][3], co [3][3];
   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_cell
         c3rb_cell u_cell (.clock(clock), .reset(reset), .shift(s1_ff),
            .col_in(ci[g]), .col_out(co[g]));
      end
   endgenerate
   always_comb begin
      ci[2][0] = up; ci[2][1] = lo; ci[2][2] = pix_ff;
      ci[1] = co[2];
      ci[0] = co[1];
   end
   pix_type win [9];
   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) win[i*3+j] = co[j][i];
   end

   logic [1:0] seq_ff;
   logic       act_ff, m2_ff, r12_ff, c12_ff, re2_ff, lr2_ff;
   logic       pr, pc;
   job_type    job;
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0; seq_ff <= '0;
      end else if (s1_ff) begin
         act_ff <= ok1_ff; seq_ff <= '0;
      end else if (act_ff) begin
         if (job.last) act_ff <= 1'b0;
         seq_ff <= seq_ff + 2'd1;
      end
      if (s1_ff) begin
         m2_ff <= m1_ff; r12_ff <= r11_ff; c12_ff <= c11_ff;
         re2_ff <= re1_ff; lr2_ff <= lr1_ff;
      end
   end
   always_comb begin
      pr = 1'b0;
      pc = 1'b0;
      if (m2_ff) begin
         if (lr2_ff && re2_ff) begin
            pr = seq_ff[1]; pc = seq_ff[0];
         end else begin
            pr = lr2_ff && seq_ff[0]; pc = re2_ff && seq_ff[0];
         end
      end
      job.valid = act_ff;
      job.r0 = (pr || r12_ff) ? 2'd1 : 2'd0;
      job.r1 = pr ? 2'd2 : 2'd1;
      job.c0 = (pc || c12_ff) ? 2'd1 : 2'd0;
      job.c1 = pc ? 2'd2 : 2'd1;
      job.last = !m2_ff || ((!lr2_ff || pr) && (!re2_ff || pc));
      job.fend = job.last && lr2_ff && re2_ff;
   end

   job_type jo;
   logic [7:0] cho [3];
   c3rb_mac u_mac (.clock(clock), .reset(reset), .win(win), .job(job),
      .krow(krow_ff), .job_out(jo), .ch_out(cho));

   always_ff @(posedge clock) begin
      if (reset) pend_ff <= '0;
      else if (acc) pend_ff <= extra;
      else if (pend_ff != 2'd0) pend_ff <= pend_ff - 2'd1;
   end

   logic [OUT_W-1:0]     fifo_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wp_ff, rp_ff;
   logic [OUT_PTR_W:0]   occ_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; occ_ff <= '0; cnt_ff <= '0;
      end else begin
         if (jo.valid) begin
            fifo_ff[wp_ff] <= {cho[0], cho[1], cho[2], jo.last, jo.fend};
            wp_ff <= wp_ff + 3'd1;
         end
         if (pop) rp_ff <= rp_ff + 3'd1;
         occ_ff <= occ_ff + 4'(jo.valid) - 4'(pop);
         cnt_ff <= cnt_ff + (acc ? 4'(nres) : 4'd0) - 4'(pop);
      end
   end
   assign rsp_valid = occ_ff != '0;
   assign {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_last_of_run, rsp_frame_end} =
      fifo_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 12'd640; height_ff <= 12'd480; mirror_ff <= 1'b1;
         krow_ff[0] <= '0; krow_ff[1] <= 48'h0000_1000_0000; krow_ff[2] <= '0;
         row_ff <= '0; col_ff <= '0;
      end else if (wr) begin
         unique case (ridx)
            REG_WIDTH:  begin width_ff <= pwdata[11:0]; row_ff <= '0; col_ff <= '0; end
            REG_HEIGHT: begin height_ff <= pwdata[11:0]; row_ff <= '0; col_ff <= '0; end
            REG_MIRROR: mirror_ff <= pwdata[0];
            REG_KTOP:   krow_ff[0] <= pwdata[47:0];
            REG_KMID:   krow_ff[1] <= pwdata[47:0];
            REG_KBOT:   krow_ff[2] <= pwdata[47:0];
            default: ;
         endcase
      end else if (acc) begin
         if (row_end) begin
            col_ff <= '0;
            row_ff <= last_row ? 12'd0 : r_eff + 12'd1;
         end else begin
            col_ff <= c_eff + 12'd1;
            row_ff <= r_eff;
         end
      end
   end

   a_stall_burst: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd0 |-> req_stall) else $error("beat taken during a border burst");
   a_credit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 4'(OUT_DEPTH)) else $error("output buffer overcommitted");
   a_fend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_last_of_run) else $error("frame end not last");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable({rsp_red_out, rsp_green_out,
         rsp_blue_out, rsp_last_of_run, rsp_frame_end}))
      else $error("stalled output beat changed");
endmodule
`default_nettype wire
